[rtl/hcd_pkg.sv]
// Shared types and constants for the HTTP chunked transfer decoder.
// No dependencies; every other file imports this package.
`default_nettype none

package hcd_pkg;

    localparam int unsigned SIZE_W = 31;

    // Largest size that fits in the size field, and the limit above which
    // one more hex digit would overflow it.
    localparam logic [SIZE_W-1:0] SIZE_MAX       = 31'h7FFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_SHIFT_MAX = 31'h07FF_FFFF;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_END     = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_UNUSED  = 2'd3
    } hcd_action_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_TRAILER  = 3'd1,
        KIND_CHUNK    = 3'd2,
        KIND_COMPLETE = 3'd3,
        KIND_ERROR    = 3'd4
    } hcd_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_BAD  = 2'd1,
        ERR_BIG  = 2'd2,
        ERR_EOF  = 2'd3
    } hcd_err_t;

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_EXT      = 4'd1,
        PH_DATA     = 4'd2,
        PH_SKIP     = 4'd3,
        PH_TRAILER  = 4'd4,
        PH_DONE     = 4'd5,
        PH_ERR_BAD  = 4'd6,
        PH_ERR_BIG  = 4'd7,
        PH_ERR_EOF  = 4'd8
    } hcd_phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } hcd_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        value;
        logic [SIZE_W-1:0] chunk_size;
        logic [1:0]        error_code;
    } hcd_result_t;

endpackage

`default_nettype wire

[rtl/hcd_in_stage.sv]
// Input register of the chunked decoder: holds one accepted transaction
// until the decode stage consumes it. Depends on hcd_pkg.
`default_nettype none

module hcd_in_stage
    import hcd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire hcd_item_t s_item,
    output logic           item_valid,
    output hcd_item_t      item,
    input  wire logic      item_take
);

    logic      valid_reg;
    hcd_item_t item_reg;

    // Free when empty, or when the held item leaves in this cycle.
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

[rtl/hcd_core.sv]
// Decode stage of the chunked decoder: framing state, size parsing and the
// result of each transaction, plus the chunk size limit register.
// Depends on hcd_pkg.
`default_nettype none

module hcd_core
    import hcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_data,
    input  wire logic              item_valid,
    input  wire hcd_item_t         item,
    input  wire logic              res_free,
    output logic                   item_take,
    output logic                   res_valid,
    output hcd_result_t            res
);

    hcd_phase_t        phase_reg, phase_next;
    logic [SIZE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [SIZE_W-1:0] acc_reg, acc_next;
    logic              seen_reg, seen_next;
    logic              ovf_reg, ovf_next;
    logic              tle_reg, tle_next;
    logic [SIZE_W-1:0] max_reg;

    logic              fire;
    logic [7:0]        c;
    logic              is_lf, is_cr, is_sp;
    logic              is_hex;
    logic [3:0]        hex_d;
    logic              line_big;
    logic [SIZE_W-1:0] bytes_dec;

    assign fire      = item_valid && res_free;
    assign item_take = fire;
    assign c         = item.byte_value;
    assign is_lf     = (c == CH_LF);
    assign is_cr     = (c == CH_CR);
    assign is_sp     = (c == CH_SPACE);
    assign line_big  = ovf_reg || (acc_reg > max_reg);
    assign bytes_dec = bytes_left_reg - 1'b1;

    always_comb begin
        is_hex = 1'b1;
        hex_d  = 4'd0;
        priority if (c >= "0" && c <= "9") begin
            hex_d = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            hex_d = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            hex_d = 4'(c - "A" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        ovf_next        = ovf_reg;
        tle_next        = tle_reg;
        if (fire) begin
            unique case (hcd_action_t'(item.action))
                ACT_BYTE: begin
                    unique case (phase_reg)
                        PH_SIZE, PH_EXT: begin
                            if (is_lf) begin
                                acc_next  = '0;
                                seen_next = 1'b0;
                                ovf_next  = 1'b0;
                                priority if (!seen_reg) begin
                                    phase_next = PH_ERR_BAD;
                                end else if (line_big) begin
                                    phase_next = PH_ERR_BIG;
                                end else if (acc_reg == '0) begin
                                    phase_next = PH_TRAILER;
                                    tle_next   = 1'b1;
                                end else begin
                                    phase_next      = PH_DATA;
                                    bytes_left_next = acc_reg;
                                end
                            end else if (phase_reg == PH_SIZE && !is_cr) begin
                                priority if (is_sp) begin
                                    phase_next = PH_EXT;
                                end else if (!is_hex) begin
                                    phase_next = PH_ERR_BAD;
                                end else begin
                                    seen_next = 1'b1;
                                    if (acc_reg > SIZE_SHIFT_MAX) begin
                                        ovf_next = 1'b1;
                                    end else begin
                                        acc_next = {acc_reg[SIZE_W-5:0], hex_d};
                                    end
                                end
                            end
                        end
                        PH_DATA: begin
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == '0) begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            if (is_lf) begin
                                phase_next = PH_SIZE;
                            end
                        end
                        PH_TRAILER: begin
                            priority if (tle_reg && is_cr) begin
                                tle_next = tle_reg;
                            end else if (tle_reg && is_lf) begin
                                phase_next = PH_DONE;
                            end else begin
                                tle_next = is_lf;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ACT_END: begin
                    unique case (phase_reg)
                        PH_SIZE, PH_EXT, PH_DATA, PH_SKIP: phase_next = PH_ERR_EOF;
                        PH_TRAILER:                        phase_next = PH_DONE;
                        default: begin
                        end
                    endcase
                end
                ACT_RESTART: begin
                    phase_next      = PH_SIZE;
                    bytes_left_next = '0;
                    acc_next        = '0;
                    seen_next       = 1'b0;
                    ovf_next        = 1'b0;
                    tle_next        = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the transaction in the input register.
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        unique case (hcd_action_t'(item.action))
            ACT_BYTE: begin
                unique case (phase_reg)
                    PH_SIZE, PH_EXT: begin
                        if (is_lf) begin
                            res_valid = 1'b1;
                            priority if (!seen_reg) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_BAD;
                            end else if (line_big) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_BIG;
                            end else begin
                                res.kind       = KIND_CHUNK;
                                res.chunk_size = acc_reg;
                            end
                        end else if (phase_reg == PH_SIZE && !is_cr && !is_sp && !is_hex) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_BAD;
                        end
                    end
                    PH_DATA: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_PAYLOAD;
                        res.value = c;
                    end
                    PH_TRAILER: begin
                        priority if (tle_reg && is_cr) begin
                            res_valid = 1'b0;
                        end else if (tle_reg && is_lf) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_COMPLETE;
                        end else begin
                            res_valid = 1'b1;
                            res.kind  = KIND_TRAILER;
                            res.value = c;
                        end
                    end
                    PH_ERR_BAD, PH_ERR_BIG, PH_ERR_EOF: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_END: begin
                unique case (phase_reg)
                    PH_SIZE, PH_EXT, PH_DATA, PH_SKIP: begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_EOF;
                    end
                    PH_TRAILER: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_COMPLETE;
                    end
                    PH_ERR_BAD, PH_ERR_BIG, PH_ERR_EOF: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        // A sticky error repeats the code that caused it.
        if (res.kind == KIND_ERROR && res.error_code == ERR_NONE) begin
            unique case (phase_reg)
                PH_ERR_BAD: res.error_code = ERR_BAD;
                PH_ERR_BIG: res.error_code = ERR_BIG;
                default:    res.error_code = ERR_EOF;
            endcase
        end
        res_valid = res_valid && fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE;
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            seen_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            tle_reg        <= 1'b1;
            max_reg        <= SIZE_MAX;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            seen_reg       <= seen_next;
            ovf_reg        <= ovf_next;
            tle_reg        <= tle_next;
            if (cfg_we) begin
                max_reg <= cfg_data;
            end
        end
    end

    a_err_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.action == ACT_BYTE || item.action == ACT_END)
        && (phase_reg == PH_ERR_BAD || phase_reg == PH_ERR_BIG || phase_reg == PH_ERR_EOF)
        |-> res_valid && res.kind == KIND_ERROR && res.error_code != ERR_NONE)
        else $error("sticky error state gave no error result");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> !res_valid)
        else $error("result produced after completion");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.action == ACT_RESTART |=> phase_reg == PH_SIZE && acc_reg == '0 && tle_reg)
        else $error("restart did not clear the framing state");

    a_data_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase entered with nothing left to pass");

endmodule

`default_nettype wire

[rtl/hcd_out_stage.sv]
// Output register of the chunked decoder: holds one result until the
// downstream side takes it. Depends on hcd_pkg.
`default_nettype none

module hcd_out_stage
    import hcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        res_valid,
    input  wire hcd_result_t res,
    output logic             res_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output hcd_result_t      m_res
);

    logic        valid_reg;
    hcd_result_t res_reg;

    assign res_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_free) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_free && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

[rtl/http_chunked_decoder.sv]
// Top level of the HTTP/1.1 chunked transfer decoder.
// Depends on hcd_pkg, hcd_in_stage, hcd_core and hcd_out_stage.
//
//  Channel   Direction  Handshake            Content
//  s_        in         s_valid / s_ready    action, byte_value
//  m_        out        m_valid / m_ready    kind, value, chunk_size, error_code
//  cfg_      in         cfg_valid / cfg_ready max_chunk_size
//
// One transaction per cycle is sustained while m_ready is high; each passes
// through the input register and the decode logic into the output register,
// where any result it produces waits until the downstream side takes it.
// Reset is synchronous and active low; the size limit resets to 0x7FFFFFFF.
// While a result waits with m_ready low, the decode stage stalls, and
// s_ready stays high only as long as the input register is empty.
// Configuration writes are always taken.
`default_nettype none

module http_chunked_decoder
    import hcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_action,
    input  wire logic [7:0]        s_byte_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_kind,
    output logic [7:0]             m_value,
    output logic [SIZE_W-1:0]      m_chunk_size,
    output logic [1:0]             m_error_code,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_max_chunk_size
);

    hcd_item_t   s_item;
    hcd_item_t   item;
    logic        item_valid;
    logic        item_take;
    logic        res_valid;
    logic        res_free;
    hcd_result_t res;
    hcd_result_t m_res;

    assign cfg_ready         = 1'b1;
    assign s_item.action     = s_action;
    assign s_item.byte_value = s_byte_value;
    assign m_kind            = m_res.kind;
    assign m_value           = m_res.value;
    assign m_chunk_size      = m_res.chunk_size;
    assign m_error_code      = m_res.error_code;

    hcd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    hcd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_max_chunk_size),
        .item_valid (item_valid),
        .item       (item),
        .res_free   (res_free),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    hcd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

endmodule

`default_nettype wire
